[sv/h64_pkg.sv]
// ----------------------------------------------------------------------------
// h64_pkg
// Shared types, codes and the Base64 alphabet for the hex-to-Base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package h64_pkg;

    // Status codes carried with every output character.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_ODD_COUNT = 2'd2
    } status_t;

    localparam int unsigned JOB_CHARS = 4;
    localparam logic [7:0]  PAD_CHAR  = 8'h3D;   // '='
    localparam logic [7:0]  ERR_CHAR  = 8'h00;

    // One decoded item: up to four characters that leave back to back.
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
        logic                      last;
        status_t                   status;
    } job_t;

    // Maps a 6-bit group onto the standard Base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

    // Decodes an ASCII hex digit; the top bit flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/h64_front.sv]
// ----------------------------------------------------------------------------
// h64_front
// Accepts hex digits, pairs them into bytes and turns each into a job of
// Base64 characters, padding and error results for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module h64_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,     // [7:0] hex_digit
    input  wire logic          s_tlast,     // final_digit
    input  wire logic          q_full,
    output logic               q_push,
    output h64_pkg::job_t      q_job
);

    logic [3:0] nib_reg, nib_next;
    logic       half_reg, half_next;
    logic [1:0] slot_reg, slot_next;
    logic [3:0] left_reg, left_next;
    logic [4:0] dec;
    logic [7:0] byte_val;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign dec      = h64_pkg::hex_decode(s_tdata);
    assign byte_val = {nib_reg, dec[3:0]};

    // Classify the digit and build the job of characters that it causes.
    always_comb begin
        nib_next  = nib_reg;
        half_next = half_reg;
        slot_next = slot_reg;
        left_next = left_reg;
        q_job        = '0;
        q_job.status = h64_pkg::ST_OK;
        if (!dec[4]) begin
            q_job.chars[0] = h64_pkg::ERR_CHAR;
            q_job.count    = 3'd1;
            q_job.last     = 1'b1;
            q_job.status   = h64_pkg::ST_BAD_DIGIT;
            nib_next  = '0;
            half_next = 1'b0;
            slot_next = '0;
            left_next = '0;
        end else if (!half_reg) begin
            if (s_tlast) begin
                q_job.chars[0] = h64_pkg::ERR_CHAR;
                q_job.count    = 3'd1;
                q_job.last     = 1'b1;
                q_job.status   = h64_pkg::ST_ODD_COUNT;
                nib_next  = '0;
                slot_next = '0;
                left_next = '0;
            end else begin
                nib_next  = dec[3:0];
                half_next = 1'b1;
            end
        end else begin
            nib_next  = '0;
            half_next = 1'b0;
            q_job.last = s_tlast;
            unique case (slot_reg)
                2'd1: begin
                    q_job.chars[0] = h64_pkg::b64_char({left_reg[1:0], byte_val[7:4]});
                    left_next = byte_val[3:0];
                    slot_next = 2'd2;
                    if (s_tlast) begin
                        q_job.chars[1] = h64_pkg::b64_char({byte_val[3:0], 2'b00});
                        q_job.chars[2] = h64_pkg::PAD_CHAR;
                        q_job.count    = 3'd3;
                    end else begin
                        q_job.count    = 3'd1;
                    end
                end
                2'd2: begin
                    q_job.chars[0] = h64_pkg::b64_char({left_reg, byte_val[7:6]});
                    q_job.chars[1] = h64_pkg::b64_char(byte_val[5:0]);
                    q_job.count    = 3'd2;
                    left_next = '0;
                    slot_next = 2'd0;
                end
                default: begin
                    // Slot zero, and the unused slot code that behaves like it.
                    q_job.chars[0] = h64_pkg::b64_char(byte_val[7:2]);
                    left_next = {2'b00, byte_val[1:0]};
                    slot_next = 2'd1;
                    if (s_tlast) begin
                        q_job.chars[1] = h64_pkg::b64_char({byte_val[1:0], 4'b0000});
                        q_job.chars[2] = h64_pkg::PAD_CHAR;
                        q_job.chars[3] = h64_pkg::PAD_CHAR;
                        q_job.count    = 3'd4;
                    end else begin
                        q_job.count    = 3'd1;
                    end
                end
            endcase
            if (s_tlast) begin
                slot_next = '0;
                left_next = '0;
            end
        end
    end

    assign q_push = accept && (q_job.count != 3'd0);

    // Message state advances only on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nib_reg  <= '0;
            half_reg <= 1'b0;
            slot_reg <= '0;
            left_reg <= '0;
        end else if (accept) begin
            nib_reg  <= nib_next;
            half_reg <= half_next;
            slot_reg <= slot_next;
            left_reg <= left_next;
        end
    end

    // A digit that completes a byte always yields at least one character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && half_reg) |-> q_push)
        else $error("completed byte produced no characters");

    // The group position never takes the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg != 2'd3)
        else $error("byte slot reached unused code");

    // Errors and final digits leave the front ready for a fresh message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tlast || !dec[4])) |=> (!half_reg && slot_reg == 2'd0))
        else $error("state not cleared at end of message");

endmodule

`default_nettype wire

[sv/h64_queue.sv]
// ----------------------------------------------------------------------------
// h64_queue
// Two-entry job queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module h64_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire h64_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               q_valid,
    output h64_pkg::job_t      q_job
);

    h64_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job written into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid))
        else $error("job taken from an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

[sv/h64_back.sv]
// ----------------------------------------------------------------------------
// h64_back
// Takes jobs from the queue and sends their characters one transfer a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module h64_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire h64_pkg::job_t q_job,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,     // [7:0] code_char
    output logic               m_tlast,     // end_of_output
    output logic [1:0]         m_tuser      // [1:0] status
);

    h64_pkg::job_t job_reg, job_next;
    logic [1:0]    idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          last_char, load;

    assign last_char = ({1'b0, idx_reg} == job_reg.count - 3'd1);
    assign load      = !busy_reg || (m_tready && last_char);
    assign pop       = load && q_valid;

    // Walk through the characters of the held job.
    always_comb begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            busy_next = q_valid;
            idx_next  = '0;
            if (q_valid) begin
                job_next = q_job;
            end
        end else if (m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.chars[idx_reg];
    assign m_tlast  = job_reg.last && last_char;
    assign m_tuser  = job_reg.status;

    // An error result is a lone zero character that ends the message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != h64_pkg::ST_OK) |-> (m_tlast && m_tdata == h64_pkg::ERR_CHAR))
        else $error("malformed error result");

    // The character index stays inside the held job.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, idx_reg} < job_reg.count))
        else $error("character index beyond job length");

    // With the queue empty, the output drains after the last character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && last_char && !q_valid) |=> !m_tvalid)
        else $error("output stayed valid with nothing to send");

endmodule

`default_nettype wire

[sv/hex_to_base64_encoder.sv]
// ----------------------------------------------------------------------------
// hex_to_base64_encoder
// Streaming hex-digit to standard Base64 encoder with padding and error
// status.
// ----------------------------------------------------------------------------
// One ASCII hex digit is taken per transfer, final_digit on s_tlast, and a
// new digit can be accepted every cycle while the two-entry job queue has
// room. Each digit becomes a job of zero to four characters; the output side
// sends one character per cycle while m_tready is high, so a completed byte
// gives one or two characters and a final byte up to four. Sustained input is
// one digit per cycle as long as the output keeps pace; the input stalls only
// while the queue is full behind a padding burst or a stalled output. An
// accepted digit's characters are registered in the job queue and then in
// the output job register. Non-hex digits give a single zero character
// with status 1, an odd digit count one with status 2; both end the message
// and start afresh.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_to_base64_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] hex_digit
    input  wire logic       s_tlast,    // final_digit
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] code_char
    output logic            m_tlast,    // end_of_output
    output logic [1:0]      m_tuser     // [1:0] status
);

    h64_pkg::job_t push_job, head_job;
    logic          push, pop, full, head_valid;

    // Digit classification and byte packing.
    h64_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    // Jobs waiting for the output side.
    h64_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .q_valid  (head_valid),
        .q_job    (head_job)
    );

    // Character serialiser.
    h64_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (head_valid),
        .q_job    (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[sim/tb_hex_to_base64_encoder.sv]
// ----------------------------------------------------------------------------
// tb_hex_to_base64_encoder
// Self-checking testbench for the streaming hex-digit to Base64 encoder.
// ----------------------------------------------------------------------------
// Hex digits are sent one per transfer on the slave side, and every accepted
// digit is run through a local model of the encoder. The model's characters
// are queued, and each transfer on the master side is compared field by
// field with the oldest queued character. Directed messages cover the
// alphabet edges, every flush length, zero bytes and both error kinds. Random
// well-formed messages and broken or noisy streams follow, with random gaps
// on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------

module tb_hex_to_base64_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTED = 10;
    localparam int DRAIN_CYCLES = 20;

    // One output character as it should appear on the master side.
    typedef struct packed {
        logic [7:0]       code;
        logic             eom;
        h64_pkg::status_t status;
    } code_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] hex_digit
    logic       s_tlast  = 1'b0;    // final_digit
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] code_char
    logic       m_tlast;            // end_of_output
    logic [1:0] m_tuser;            // [1:0] status

    // Local copy of the encoder state.
    logic [3:0] enc_high_nibble = 4'd0;
    logic       enc_low_due     = 1'b0;
    logic [1:0] enc_slot        = 2'd0;
    logic [3:0] enc_carry       = 4'd0;

    code_t      chars_due [$];
    code_t      got_code;
    code_t      want_code;
    string      b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    int         cycles         = 0;
    int         mismatches     = 0;
    int         digits_sent    = 0;
    int         chars_checked  = 0;
    int         messages_done  = 0;
    int         error_results  = 0;
    bit         in_idling      = 1'b0;
    bit         out_idling     = 1'b0;
    int         ready_hold     = 0;

    hex_to_base64_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Maps a 6-bit group onto its character through the alphabet string.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    // Works out the characters one accepted digit gives and queues them.
    task automatic encode_digit(input logic [7:0] c, input logic fin);
        logic [4:0] nib;
        logic [7:0] b;
        logic [7:0] out_chars [4];
        int         n;
        n   = 0;
        nib = 5'd0;
        // Decimal digits carry their value in the low nibble; letters sit nine
        // below theirs, in either case.
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            nib = {1'b1, 4'(c[3:0] + 4'd9)};
        end

        if (!nib[4]) begin
            // A non-hex character ends the message at once.
            {enc_high_nibble, enc_low_due, enc_slot, enc_carry} = '0;
            chars_due.push_back('{h64_pkg::ERR_CHAR, 1'b1, h64_pkg::ST_BAD_DIGIT});
            messages_done++;
            error_results++;
        end else if (!enc_low_due) begin
            if (fin) begin
                // The message ends on half a byte.
                {enc_high_nibble, enc_low_due, enc_slot, enc_carry} = '0;
                chars_due.push_back('{h64_pkg::ERR_CHAR, 1'b1, h64_pkg::ST_ODD_COUNT});
                messages_done++;
                error_results++;
            end else begin
                enc_high_nibble = nib[3:0];
                enc_low_due     = 1'b1;
            end
        end else begin
            b = {enc_high_nibble, nib[3:0]};
            enc_high_nibble = 4'd0;
            enc_low_due     = 1'b0;
            case (enc_slot)
                2'd1: begin
                    out_chars[0] = sextet_char({enc_carry[1:0], b[7:4]});
                    n            = 1;
                    enc_carry    = b[3:0];
                    enc_slot     = 2'd2;
                end
                2'd2: begin
                    out_chars[0] = sextet_char({enc_carry, b[7:6]});
                    out_chars[1] = sextet_char(b[5:0]);
                    n            = 2;
                    enc_carry    = 4'd0;
                    enc_slot     = 2'd0;
                end
                default: begin
                    out_chars[0] = sextet_char(b[7:2]);
                    n            = 1;
                    enc_carry    = {2'b00, b[1:0]};
                    enc_slot     = 2'd1;
                end
            endcase
            // On the last byte the leftover bits go out zero-filled, then padding.
            if (fin) begin
                if (enc_slot == 2'd1) begin
                    out_chars[n]     = sextet_char({enc_carry[1:0], 4'd0});
                    out_chars[n + 1] = h64_pkg::PAD_CHAR;
                    out_chars[n + 2] = h64_pkg::PAD_CHAR;
                    n                = n + 3;
                end else if (enc_slot == 2'd2) begin
                    out_chars[n]     = sextet_char({enc_carry, 2'd0});
                    out_chars[n + 1] = h64_pkg::PAD_CHAR;
                    n                = n + 2;
                end
                {enc_high_nibble, enc_low_due, enc_slot, enc_carry} = '0;
                messages_done++;
            end
            for (int i = 0; i < n; i++) begin
                chars_due.push_back('{out_chars[i], fin && (i == n - 1), h64_pkg::ST_OK});
            end
        end
    endtask

    // Predicts on every input transfer and checks every output transfer.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                encode_digit(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got_code = '{m_tdata, m_tlast, h64_pkg::status_t'(m_tuser)};
                if (chars_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED) begin
                        $display("ERROR: unexpected character %h last %b status %0d",
                                 m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    want_code = chars_due.pop_front();
                    chars_checked++;
                    if (got_code !== want_code) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTED) begin
                            $display("ERROR: character %0d expected %h/%b/%0d got %h/%b/%0d",
                                     chars_checked, want_code.code, want_code.eom,
                                     want_code.status, got_code.code, got_code.eom,
                                     got_code.status);
                        end
                    end
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Back-pressure when idling: runs of ready and stalls, mostly short.
    always @(posedge aclk) begin
        if (!out_idling) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(0, 3);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end
    end

    // Input gap ahead of a digit, mostly none or short, now and then long.
    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_idling || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Sends one digit and returns at the edge of its transfer.
    task automatic send_digit(input logic [7:0] c, input logic fin);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        digits_sent++;
    endtask

    // Sends a string of characters, the last one final when mark_last is set.
    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++) begin
            send_digit(s[i], mark_last && (i == s.len() - 1));
        end
    endtask

    // A random valid hex digit in either letter case.
    function automatic logic [7:0] random_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'(8'h30 + v);
        end
        return 8'((($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    // Byte count for a message: mostly one to four, a few longer ones.
    function automatic int message_bytes();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    endfunction

    // Fixed messages: every flush length, alphabet edges and both errors.
    task automatic test_directed();
        in_idling  = 1'b0;
        out_idling = 1'b0;
        send_text("9a", 1'b1);      // one byte, two pads
        send_text("4D616e", 1'b1);  // full group, no padding
        send_text("FbEf", 1'b1);    // two bytes, one pad, plus signs
        send_text("00", 1'b1);      // zero byte is encoded
        send_text("fF", 1'b1);      // one slash
        send_text("5", 1'b1);       // odd count on a lone digit
        send_text("g", 1'b1);       // bad digit wins over the odd count
        send_text("1:", 1'b0);      // bad digit after a high nibble
        send_digit(8'h00, 1'b0);
        send_digit(8'hFF, 1'b1);
        send_text("@`G/", 1'b0);    // characters just outside each digit range
        send_text("ABC", 1'b1);     // odd count after a whole byte
    endtask

    // Well-formed messages with random content.
    task automatic test_messages(input int n_digits, input bit idle);
        int target;
        int nb;
        in_idling  = idle;
        out_idling = idle;
        target     = digits_sent + n_digits;
        while (digits_sent < target) begin
            nb = message_bytes();
            for (int i = 0; i < 2 * nb; i++) begin
                send_digit(random_hex(), i == 2 * nb - 1);
            end
        end
    endtask

    // Broken messages: stray characters, odd lengths and raw noise.
    task automatic test_broken(input int n_digits);
        int target;
        int nb;
        int kind;
        int spot;
        in_idling  = 1'b1;
        out_idling = 1'b1;
        target     = digits_sent + n_digits;
        while (digits_sent < target) begin
            kind = $urandom_range(0, 2);
            nb   = message_bytes();
            case (kind)
                0: begin
                    // One character replaced by an arbitrary byte.
                    spot = $urandom_range(0, 2 * nb - 1);
                    for (int i = 0; i < 2 * nb; i++) begin
                        send_digit((i == spot) ? 8'($urandom_range(0, 255)) : random_hex(),
                                   i == 2 * nb - 1);
                    end
                end
                1: begin
                    // Odd number of valid digits.
                    for (int i = 0; i < 2 * nb - 1; i++) begin
                        send_digit(random_hex(), i == 2 * nb - 2);
                    end
                end
                default: begin
                    // Arbitrary bytes with random final marks.
                    for (int i = 0; i < nb; i++) begin
                        send_digit(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    end
                end
            endcase
        end
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_messages(60, 1'b0);
        test_messages(150, 1'b1);
        test_broken(90);
        s_tvalid <= 1'b0;
        while (chars_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d hex digits in %0d messages, with and without idling on both sides.",
                 digits_sent, messages_done);
        $display("Checked %0d output characters, %0d of them error results.",
                 chars_checked, error_results);
        if (mismatches == 0 && chars_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Mismatches: %0d, characters never seen: %0d",
                     mismatches, chars_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
